[hw/rtl/lru_assoc_cell_cache_defines.svh]
// Assertion helpers shared by the cache RTL.
`ifndef LRU_ASSOC_CELL_CACHE_DEFINES_SVH
`define LRU_ASSOC_CELL_CACHE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LACC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lacc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LACC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lacc: next-cycle check failed");

`endif

[hw/rtl/lacc_pkg.sv]
package lacc_pkg;

    localparam int LACC_ENTRIES = 64;

    localparam int MODE_W    = 2;
    localparam int KEY_W     = 32;
    localparam int DATA_W    = 64;
    localparam int SLOT_W    = 6;

    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;
    localparam int M_PAD_W   = M_TDATA_W - DATA_W - SLOT_W;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TOUCH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic latch_hit;
        logic sel_victim;
        logic sel_free;
        logic data_rd;
        logic data_wr;
        logic key_wr;
        logic link_rd;
        logic fill_inc;
        logic set_oldest;
        logic unlink;
        logic append;
        logic set_stored;
        logic load_result;
    } lacc_cmd_t;

    typedef struct packed {
        logic              found;
        logic              exhausted;
        logic              is_newest;
        logic              is_oldest;
        logic              full;
        logic              allow;
        logic [MODE_W-1:0] mode;
    } lacc_status_t;

endpackage

[hw/rtl/lru_assoc_cell_cache.sv]
// Fully associative cache of up to ENTRIES keyed 64-bit entries with least recently used
// replacement, kept as a doubly linked recency list in two link memories. Each input
// transaction carries a mode (plain lookup, lookup that marks the entry most recent, or
// update/insert), a 32-bit key, the update data and an insert permission, and yields
// exactly one result transaction with hit, data, slot and stored. One transaction is
// processed at a time: the key search walks the key memory one entry per cycle over the
// filled entries only, and a new transaction is accepted only after the last one has
// loaded its result, the search being the dominant part of the work. The result sits in
// an output register, so the next transaction is accepted while a result waits. After
// reset the cache is empty and ready at once; no clearing pass is needed, as entries are
// filled in index order and the fill count marks which are valid.
`include "lru_assoc_cell_cache_defines.svh"

module lru_assoc_cell_cache
    import lacc_pkg::*;
#(
    parameter int ENTRIES = LACC_ENTRIES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // key [31:0], data_in [95:32]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode [1:0], allow_insert [2]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // data_out [63:0], slot [69:64], zero padding [71:70]
    output logic [M_TDATA_W-1:0] m_tdata,
    // hit [0], stored [1]
    output logic [M_TUSER_W-1:0] m_tuser
);

    lacc_cmd_t    ctrl_cmd;
    lacc_status_t dp_status;

    lacc_dpath #(
        .ENTRIES(ENTRIES)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ctrl_cmd),
        .status  (dp_status),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    lacc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    `LACC_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `LACC_ASSERT_NOW(a_store_no_data, aclk, aresetn, m_tvalid && m_tuser[1], m_tdata[63:0] == 64'd0)
    `LACC_ASSERT_NOW(a_miss_all_zero, aclk, aresetn, m_tvalid && !m_tuser[0] && !m_tuser[1], m_tdata == '0)
    `LACC_ASSERT_NOW(a_unlink_not_newest, aclk, aresetn, ctrl_cmd.unlink, !dp_status.is_newest && !dp_status.is_oldest)

endmodule

[hw/rtl/lacc_dpath.sv]
module lacc_dpath
    import lacc_pkg::*;
#(
    parameter int ENTRIES = LACC_ENTRIES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lacc_cmd_t            cmd,
    output lacc_status_t         status,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0]     key_mem_reg   [ENTRIES];
    logic [DATA_W-1:0]    data_mem_reg  [ENTRIES];
    logic [IW-1:0]        older_mem_reg [ENTRIES];
    logic [IW-1:0]        newer_mem_reg [ENTRIES];

    logic [KEY_W-1:0]     key_reg;
    logic [DATA_W-1:0]    din_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic                 allow_reg;
    logic [KEY_W-1:0]     key_rd_reg;
    logic [DATA_W-1:0]    data_rd_reg;
    logic [IW-1:0]        older_rd_reg;
    logic [IW-1:0]        newer_rd_reg;
    logic [IW-1:0]        cmp_idx_reg;
    logic [IW-1:0]        s_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic [CW-1:0]        scan_cnt_reg;
    logic                 cmp_vld_reg;
    logic [CW-1:0]        fill_reg;
    logic [IW-1:0]        oldest_reg;
    logic [IW-1:0]        newest_reg;
    logic                 hit_reg;
    logic                 stored_reg;

    logic                 scan_more;
    logic [SLOT_W-1:0]    res_slot;
    logic [DATA_W-1:0]    res_data;
    logic                 is_lookup;

    assign scan_more = scan_cnt_reg < fill_reg;
    assign is_lookup = (mode_reg == MODE_LOOKUP) || (mode_reg == MODE_TOUCH);
    assign res_slot  = (hit_reg || stored_reg) ? SLOT_W'(s_reg) : '0;
    assign res_data  = (hit_reg && is_lookup) ? data_rd_reg : '0;

    assign status.found     = cmp_vld_reg && (key_rd_reg == key_reg);
    assign status.exhausted = !cmp_vld_reg && !scan_more;
    assign status.is_newest = s_reg == newest_reg;
    assign status.is_oldest = s_reg == oldest_reg;
    assign status.full      = fill_reg == CW'(ENTRIES);
    assign status.allow     = allow_reg;
    assign status.mode      = mode_reg;

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            fill_reg     <= '0;
            oldest_reg   <= '0;
            newest_reg   <= '0;
            hit_reg      <= 1'b0;
            stored_reg   <= 1'b0;
        end else begin
            if (cmd.capture) begin
                scan_cnt_reg <= '0;
                cmp_vld_reg  <= 1'b0;
                hit_reg      <= 1'b0;
                stored_reg   <= 1'b0;
            end else if (cmd.scan_step) begin
                cmp_vld_reg <= scan_more;
                if (scan_more) begin
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
            end
            if (cmd.latch_hit) begin
                hit_reg <= 1'b1;
            end
            if (cmd.set_stored) begin
                stored_reg <= 1'b1;
            end
            if (cmd.fill_inc) begin
                fill_reg <= fill_reg + CW'(1);
            end
            if (cmd.set_oldest) begin
                oldest_reg <= newer_rd_reg;
            end
            if (cmd.append) begin
                newest_reg <= s_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg   <= s_tdata[KEY_W-1:0];
            din_reg   <= s_tdata[KEY_W+DATA_W-1:KEY_W];
            mode_reg  <= s_tuser[MODE_W-1:0];
            allow_reg <= s_tuser[MODE_W];
        end
        if (cmd.scan_step && scan_more) begin
            key_rd_reg  <= key_mem_reg[scan_cnt_reg[IW-1:0]];
            cmp_idx_reg <= scan_cnt_reg[IW-1:0];
        end
        if (cmd.latch_hit) begin
            s_reg <= cmp_idx_reg;
        end else if (cmd.sel_victim) begin
            s_reg <= oldest_reg;
        end else if (cmd.sel_free) begin
            s_reg <= fill_reg[IW-1:0];
        end
        if (cmd.key_wr) begin
            key_mem_reg[s_reg] <= key_reg;
        end
        if (cmd.data_wr) begin
            data_mem_reg[s_reg] <= din_reg;
        end
        if (cmd.data_rd) begin
            data_rd_reg <= data_mem_reg[s_reg];
        end
        if (cmd.link_rd) begin
            older_rd_reg <= older_mem_reg[s_reg];
            newer_rd_reg <= newer_mem_reg[s_reg];
        end
        if (cmd.unlink) begin
            newer_mem_reg[older_rd_reg] <= newer_rd_reg;
            older_mem_reg[newer_rd_reg] <= older_rd_reg;
        end else if (cmd.append) begin
            newer_mem_reg[newest_reg] <= s_reg;
            older_mem_reg[s_reg]      <= newest_reg;
        end
        if (cmd.load_result) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, res_slot, res_data};
            m_tuser_reg <= {stored_reg, hit_reg};
        end
    end

endmodule

[hw/rtl/lacc_ctrl.sv]
module lacc_ctrl
    import lacc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  lacc_status_t status,
    output lacc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS,
        ST_INSERT,
        ST_UNLINK,
        ST_APPEND,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_vld_reg;
    logic   out_vld_next;
    logic   mode_unused;

    assign mode_unused = (status.mode != MODE_LOOKUP) && (status.mode != MODE_TOUCH)
                         && (status.mode != MODE_UPDATE);
    assign s_tready    = state_reg == ST_IDLE;
    assign m_tvalid    = out_vld_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        out_vld_next = out_vld_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (mode_unused) begin
                    state_next = ST_DONE;
                end else if (status.found) begin
                    cmd.latch_hit = 1'b1;
                    state_next    = ST_HIT;
                end else if (status.exhausted) begin
                    state_next = ST_MISS;
                end
            end
            ST_HIT: begin
                case (status.mode)
                    MODE_LOOKUP: begin
                        cmd.data_rd = 1'b1;
                        state_next  = ST_DONE;
                    end
                    MODE_TOUCH: begin
                        cmd.data_rd = 1'b1;
                        cmd.link_rd = 1'b1;
                        state_next  = ST_UNLINK;
                    end
                    MODE_UPDATE: begin
                        cmd.data_wr    = 1'b1;
                        cmd.set_stored = 1'b1;
                        state_next     = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MISS: begin
                if (status.mode == MODE_UPDATE && status.allow) begin
                    cmd.sel_victim = status.full;
                    cmd.sel_free   = !status.full;
                    state_next     = ST_INSERT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_INSERT: begin
                cmd.key_wr     = 1'b1;
                cmd.data_wr    = 1'b1;
                cmd.set_stored = 1'b1;
                if (status.full) begin
                    cmd.link_rd = 1'b1;
                    state_next  = ST_UNLINK;
                end else begin
                    cmd.fill_inc = 1'b1;
                    state_next   = ST_APPEND;
                end
            end
            ST_UNLINK: begin
                if (status.is_newest) begin
                    state_next = ST_DONE;
                end else if (status.is_oldest) begin
                    cmd.set_oldest = 1'b1;
                    state_next     = ST_APPEND;
                end else begin
                    cmd.unlink = 1'b1;
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    cmd.load_result = 1'b1;
                    out_vld_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule
